>>> rtl/core/frequency_stack_level_stacks_macros.svh
// assertion macros shared by the frequency stack rtl
// expects clk and arst_n in the scope of each use
`ifndef FREQUENCY_STACK_LEVEL_STACKS_MACROS_SVH
`define FREQUENCY_STACK_LEVEL_STACKS_MACROS_SVH

// combinational property checked on every rising clock edge out of reset
`define FSLS_CHECK(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// cause in one cycle, effect in the next
`define FSLS_CHECK_NEXT(lbl, cause, effect, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cause) |=> (effect)) \
		else $error(msg);

`endif

>>> rtl/core/fsls_pkg.sv
// shared types and constants of the frequency stack
// no dependencies
`default_nettype none
package fsls_pkg;
	localparam int CAPACITY = 256;
	localparam int IDX_W    = 8;
	localparam int CNT_W    = 9;
	localparam int VAL_W    = 32;
	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_NODE, S_LINK, S_P1, S_P2, S_P3, S_DONE
	} state_t;

	typedef struct packed {
		logic [VAL_W-1:0] key;
		logic [CNT_W-1:0] cnt;
	} key_ent_t;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic [IDX_W-1:0] below;
		logic [IDX_W-1:0] slot;
	} node_ent_t;

	localparam int KEY_W  = $bits(key_ent_t);
	localparam int NODE_W = $bits(node_ent_t);
endpackage
`default_nettype wire

>>> rtl/core/fsls_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module fsls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/frequency_stack_level_stacks.sv
// maximum-frequency stack: each push files a value on the stack of its new
// occurrence count, each pop takes the top of the highest level.
// input channel in_valid/in_stall with op and value, one result per transaction
// on out_valid/out_stall with pop_value, status, top_level and occupancy.
// a pop goes through states p1, p2 and p3 before its result is done. a push
// goes through node and link after the key search: the key memory is read one slot
// a cycle until the value is found, the whole memory in the worst case, when the value
// is new. a rejected push (full) or a pop on an empty stack goes straight to done.
// one transaction is worked on at a time; a finished result waits in the done
// state while out_stall holds the output register, and in_stall stays high.
// after reset the stack is empty with zero top level and occupancy counts (the
// output registers are not reset), the block is ready at once, the memories need
// no clearing pass: node indices come from a fill count, key slots have valid flops.
// depends on fsls_pkg, fsls_ram and the assertion macro header
`default_nettype none
`include "frequency_stack_level_stacks_macros.svh"
module frequency_stack_level_stacks (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       op,
	input  wire logic signed [fsls_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic signed [fsls_pkg::VAL_W-1:0] pop_value,
	output logic [1:0]                      status,
	output logic [fsls_pkg::CNT_W-1:0]      top_level,
	output logic [fsls_pkg::CNT_W-1:0]      occupancy
);
	import fsls_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0] total_q, max_q, sp_q, fresh_q;
	logic [CAPACITY-1:0] kvalid_q;
	logic [VAL_W-1:0] val_q;
	logic [CNT_W-1:0] scan_q;
	logic             chk_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             free_found_q;
	logic [IDX_W-1:0] free_slot_q, slot_q, node_q;
	logic [CNT_W-1:0] cnt_q;
	status_t          res_status_q;
	logic [VAL_W-1:0] res_pop_q;

	// memory ports
	logic             key_we, node_we, lt_we, fs_we;
	logic [IDX_W-1:0] key_wa, key_ra, node_wa, node_ra, lt_wa, lt_ra, fs_wa, fs_ra;
	key_ent_t         key_wd, key_rd;
	node_ent_t        node_wd, node_rd;
	logic [IDX_W-1:0] lt_wd, lt_rd, fs_wd, fs_rd;

	fsls_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_wa), .wdata(key_wd),
		.raddr(key_ra), .rdata(key_rd)
	);
	fsls_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_node_ram (
		.clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd),
		.raddr(node_ra), .rdata(node_rd)
	);
	fsls_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_level_ram (
		.clk(clk), .we(lt_we), .waddr(lt_wa), .wdata(lt_wd),
		.raddr(lt_ra), .rdata(lt_rd)
	);
	fsls_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free_ram (
		.clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd),
		.raddr(fs_ra), .rdata(fs_rd)
	);

	logic             hit;
	logic [CNT_W-1:0] lvl;
	logic [IDX_W-1:0] new_node;
	logic [CNT_W-1:0] max_m1;
	logic             out_free;

	assign in_stall = (state_q != S_IDLE);
	assign hit      = chk_s1 && kvalid_q[idx_s1] && (key_rd.key == val_q);
	assign lvl      = cnt_q + CNT_W'(1);
	assign new_node = (sp_q != '0) ? fs_rd : fresh_q[IDX_W-1:0];
	assign max_m1   = max_q - CNT_W'(1);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		state_d = state_q;
		key_we  = 1'b0;
		key_wa  = slot_q;
		key_wd  = '{key: val_q, cnt: lvl};
		key_ra  = scan_q[IDX_W-1:0];
		node_we = 1'b0;
		node_wa = new_node;
		node_wd = '{value: val_q, below: new_node, slot: slot_q};
		node_ra = lt_rd;
		lt_we   = 1'b0;
		lt_wa   = cnt_q[IDX_W-1:0];
		lt_wd   = new_node;
		lt_ra   = cnt_q[IDX_W-1:0];
		fs_we   = 1'b0;
		fs_wa   = sp_q[IDX_W-1:0];
		fs_wd   = node_q;
		fs_ra   = sp_q[IDX_W-1:0] - IDX_W'(1);
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_PUSH) begin
						state_d = (total_q == CAP_CNT) ? S_DONE : S_SCAN;
					end else begin
						state_d = (total_q == '0) ? S_DONE : S_P1;
					end
				end
			end
			S_SCAN: begin
				if (hit || (chk_s1 && idx_s1 == LAST_IDX)) begin
					state_d = S_NODE;
				end
			end
			S_NODE: begin
				key_we  = 1'b1;
				state_d = S_LINK;
			end
			S_LINK: begin
				node_we = 1'b1;
				if (lvl <= max_q) begin
					node_wd.below = lt_rd;
				end
				lt_we   = 1'b1;
				state_d = S_DONE;
			end
			S_P1: begin
				lt_ra   = max_m1[IDX_W-1:0];
				state_d = S_P2;
			end
			S_P2: begin
				state_d = S_P3;
			end
			S_P3: begin
				// the popped value's count always equals the level it sat on
				key_we = 1'b1;
				key_wa = node_rd.slot;
				key_wd = '{key: node_rd.value, cnt: max_m1};
				if (node_rd.below != node_q) begin
					lt_we = 1'b1;
					lt_wa = max_m1[IDX_W-1:0];
					lt_wd = node_rd.below;
				end
				fs_we   = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			max_q        <= '0;
			sp_q         <= '0;
			fresh_q      <= '0;
			kvalid_q     <= '0;
			chk_s1       <= 1'b0;
			free_found_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					chk_s1       <= 1'b0;
					free_found_q <= 1'b0;
				end
				S_SCAN: begin
					chk_s1 <= 1'b1;
					if (chk_s1 && !kvalid_q[idx_s1] && !free_found_q) begin
						free_found_q <= 1'b1;
					end
				end
				S_NODE: begin
					kvalid_q[slot_q] <= 1'b1;
				end
				S_LINK: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - CNT_W'(1);
					end else begin
						fresh_q <= fresh_q + CNT_W'(1);
					end
					if (lvl > max_q) begin
						max_q <= lvl;
					end
					total_q <= total_q + CNT_W'(1);
				end
				S_P3: begin
					if (node_rd.below == node_q) begin
						max_q <= max_m1;
					end
					if (max_m1 == '0) begin
						kvalid_q[node_rd.slot] <= 1'b0;
					end
					sp_q    <= sp_q + CNT_W'(1);
					total_q <= total_q - CNT_W'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				val_q     <= value;
				scan_q    <= '0;
				res_pop_q <= '0;
				if (op == OP_PUSH) begin
					res_status_q <= (total_q == CAP_CNT) ? ST_FULL : ST_DONE;
				end else begin
					res_status_q <= (total_q == '0) ? ST_EMPTY : ST_DONE;
				end
			end
			S_SCAN: begin
				scan_q <= scan_q + CNT_W'(1);
				idx_s1 <= scan_q[IDX_W-1:0];
				if (chk_s1 && !kvalid_q[idx_s1] && !free_found_q) begin
					free_slot_q <= idx_s1;
				end
				if (hit) begin
					slot_q <= idx_s1;
					cnt_q  <= key_rd.cnt;
				end else if (chk_s1 && idx_s1 == LAST_IDX) begin
					// new value: the lowest free slot seen, the last one if none earlier
					slot_q <= free_found_q ? free_slot_q : idx_s1;
					cnt_q  <= '0;
				end
			end
			S_P2: begin
				node_q <= lt_rd;
			end
			S_P3: begin
				res_pop_q <= node_rd.value;
			end
			S_DONE: begin
				if (out_free) begin
					pop_value <= res_pop_q;
					status    <= res_status_q;
					top_level <= max_q;
					occupancy <= total_q;
				end
			end
			default: ;
		endcase
	end

	`FSLS_CHECK(a_occ_bound, total_q <= CAP_CNT, "occupancy above capacity")
	`FSLS_CHECK(a_level_bound, max_q <= total_q, "top level above occupancy")
	`FSLS_CHECK(a_node_account, sp_q + total_q == fresh_q, "node accounting broken")
	`FSLS_CHECK_NEXT(a_pop_level, state_q == S_P3 && total_q == CNT_W'(1),
		max_q == '0, "last pop left a level")
	`FSLS_CHECK(a_status_code, !out_valid || status != 2'd3, "undefined status code")
endmodule
`default_nettype wire
